@@ rtl/polyphonic_voice_allocator_defines.svh @@
// ----------------------------------------------------------------------------
// polyphonic_voice_allocator_defines
// assertion macros for the voice allocator, sampled on clk, masked by rst
// ----------------------------------------------------------------------------
`ifndef POLYPHONIC_VOICE_ALLOCATOR_DEFINES_SVH
`define POLYPHONIC_VOICE_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define PVA_ASSERT_IMP(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("voice allocator check failed");

// next-cycle implication
`define PVA_ASSERT_NXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("voice allocator check failed");

`endif

@@ rtl/pva_pkg.sv @@
// ----------------------------------------------------------------------------
// pva_pkg
// shared types and constants of the polyphonic voice allocator
// ----------------------------------------------------------------------------
package pva_pkg;

  localparam int VOICES_DEFAULT = 8;

  localparam logic [1:0] ACT_NOTE_ON  = 2'd0;
  localparam logic [1:0] ACT_NOTE_OFF = 2'd1;
  localparam logic [1:0] ACT_ALL_OFF  = 2'd2;
  localparam logic [1:0] ACT_REPORT   = 2'd3;

  typedef enum logic [2:0] {
    OP_REPORT,
    OP_REJECT,
    OP_ALLOFF,
    OP_NOTEOFF,
    OP_NOTEON
  } op_t;

  typedef enum logic [1:0] {
    RES_DONE    = 2'd0,
    RES_REJECT  = 2'd1,
    RES_NOMATCH = 2'd2
  } res_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic issue;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic needs_scan;
    logic last_issue;
    logic out_free;
  } dp_stat_t;

endpackage

@@ rtl/pva_ctrl.sv @@
// ----------------------------------------------------------------------------
// pva_ctrl
// sequencer: accept, slot scan, drain, commit of one event beat
// ----------------------------------------------------------------------------
module pva_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               event_valid,
  output logic               event_stall,
  input  pva_pkg::dp_stat_t  stat,
  output pva_pkg::ctl_cmd_t  cmd
);

  pva_pkg::state_t state;
  pva_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pva_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      pva_pkg::S_IDLE: begin
        if (event_valid) begin
          state_next = stat.needs_scan ? pva_pkg::S_SCAN : pva_pkg::S_COMMIT;
        end
      end
      pva_pkg::S_SCAN: begin
        if (stat.last_issue) begin
          state_next = pva_pkg::S_DRAIN;
        end
      end
      pva_pkg::S_DRAIN: begin
        state_next = pva_pkg::S_COMMIT;
      end
      pva_pkg::S_COMMIT: begin
        if (stat.out_free) begin
          state_next = pva_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = pva_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    event_stall = 1'b1;
    cmd         = '0;
    case (state)
      pva_pkg::S_IDLE: begin
        event_stall = 1'b0;
        cmd.accept  = event_valid;
      end
      pva_pkg::S_SCAN: begin
        cmd.issue = 1'b1;
      end
      pva_pkg::S_DRAIN: begin
        cmd = '0;
      end
      pva_pkg::S_COMMIT: begin
        cmd.commit = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ rtl/pva_dp.sv @@
// ----------------------------------------------------------------------------
// pva_dp
// voice table, slot memories, scan compare unit and result register
// ----------------------------------------------------------------------------
module pva_dp #(
  parameter int VOICES = pva_pkg::VOICES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  pva_pkg::ctl_cmd_t  cmd,
  output pva_pkg::dp_stat_t  stat,
  input  logic               cfg_wr,
  input  logic               cfg_data,
  input  logic [1:0]         action,
  input  logic [6:0]         note,
  input  logic [3:0]         channel,
  input  logic [31:0]        note_id,
  input  logic [15:0]        velocity,
  input  logic [2:0]         report_slot,
  input  logic [15:0]        report_level,
  input  logic               report_ended,
  input  logic               result_stall,
  output logic               result_valid,
  output logic [1:0]         status,
  output logic [2:0]         slot,
  output logic               stolen,
  output logic [31:0]        order_stamp,
  output logic [15:0]        start_velocity,
  output logic [7:0]         release_mask
);

  localparam int IW = $clog2(VOICES);

  logic engine_on;

  pva_pkg::op_t op_in;
  pva_pkg::op_t op_q;
  logic [6:0]   note_q;
  logic [3:0]   chan_q;
  logic [31:0]  id_q;
  logic [15:0]  vel_q;
  logic [2:0]   rslot_q;
  logic [15:0]  rlevel_q;
  logic         rended_q;

  logic [VOICES-1:0] active;
  logic [VOICES-1:0] releasing;
  logic [31:0]       order_counter;

  logic [6:0]  note_mem  [VOICES];
  logic [3:0]  chan_mem  [VOICES];
  logic [31:0] id_mem    [VOICES];
  logic [15:0] level_mem [VOICES];
  logic [31:0] order_mem [VOICES];

  logic [IW-1:0] cnt;
  logic          rd_vld;
  logic [IW-1:0] rd_idx;
  logic [6:0]    rd_note;
  logic [3:0]    rd_chan;
  logic [31:0]   rd_id;
  logic [15:0]   rd_level;
  logic [31:0]   rd_order;

  logic          have_best;
  logic [IW-1:0] best_idx;
  logic [31:0]   best_order;
  logic          best_rel;
  logic [15:0]   best_level;
  logic          free_found;
  logic [IW-1:0] free_idx;

  logic act_i;
  logic rel_i;
  logic off_take;
  logic steal_cmp;
  logic steal_take;
  logic free_take;

  logic [IW-1:0]     pick;
  logic [31:0]       stamp_next;
  logic [IW+2:0]     rs_ext;
  logic              rs_in_range;
  logic [IW-1:0]     rs_addr;
  logic [VOICES-1:0] newrel;
  logic [7:0]        newrel_mask;
  logic [IW+2:0]     best_ext;
  logic [IW+2:0]     pick_ext;
  logic [7:0]        best_onehot;

  pva_pkg::res_t res_status;
  logic [2:0]    res_slot;
  logic          res_stolen;
  logic [31:0]   res_stamp;
  logic [15:0]   res_vel;
  logic [7:0]    res_mask;

  // engine ready register
  always_ff @(posedge clk) begin
    if (rst) begin
      engine_on <= 1'b0;
    end else if (cfg_wr) begin
      engine_on <= cfg_data;
    end
  end

  always_comb begin
    if (action == pva_pkg::ACT_REPORT) begin
      op_in = pva_pkg::OP_REPORT;
    end else if (!engine_on) begin
      op_in = pva_pkg::OP_REJECT;
    end else if (action == pva_pkg::ACT_ALL_OFF) begin
      op_in = pva_pkg::OP_ALLOFF;
    end else if (action == pva_pkg::ACT_NOTE_OFF || velocity == 16'd0) begin
      op_in = pva_pkg::OP_NOTEOFF;
    end else begin
      op_in = pva_pkg::OP_NOTEON;
    end
  end

  assign stat.needs_scan = (op_in == pva_pkg::OP_NOTEON) || (op_in == pva_pkg::OP_NOTEOFF);
  assign stat.last_issue = (cnt == IW'(VOICES - 1));
  assign stat.out_free   = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q     <= op_in;
      note_q   <= note;
      chan_q   <= channel;
      id_q     <= note_id;
      vel_q    <= velocity;
      rslot_q  <= report_slot;
      rlevel_q <= report_level;
      rended_q <= report_ended;
    end
  end

  // scan address and read pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.issue;
      if (cmd.accept) begin
        cnt <= '0;
      end else if (cmd.issue) begin
        cnt <= cnt + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_idx <= cnt;
    end
  end

  // commit values
  assign pick       = free_found ? free_idx : best_idx;
  assign stamp_next = order_counter + 32'd1;
  assign rs_ext     = (IW + 3)'(rslot_q);
  assign rs_in_range = rs_ext < (IW + 3)'(VOICES);
  assign rs_addr    = rs_ext[IW-1:0];
  assign newrel     = active & ~releasing;

  for (genvar b = 0; b < 8; b++) begin : g_mask
    if (b < VOICES) begin : g_in
      assign newrel_mask[b] = newrel[b];
    end else begin : g_out
      assign newrel_mask[b] = 1'b0;
    end
  end

  assign best_ext    = (IW + 3)'(best_idx);
  assign pick_ext    = (IW + 3)'(pick);
  assign best_onehot = (best_ext < (IW + 3)'(8)) ? (8'd1 << best_ext[2:0]) : 8'd0;

  wire noteon_commit = cmd.commit && (op_q == pva_pkg::OP_NOTEON);
  wire report_commit = cmd.commit && (op_q == pva_pkg::OP_REPORT) && rs_in_range;

  // slot memories
  always_ff @(posedge clk) begin
    if (noteon_commit) begin
      note_mem[pick] <= note_q;
    end
    if (cmd.issue) begin
      rd_note <= note_mem[cnt];
    end
  end

  always_ff @(posedge clk) begin
    if (noteon_commit) begin
      chan_mem[pick] <= chan_q;
    end
    if (cmd.issue) begin
      rd_chan <= chan_mem[cnt];
    end
  end

  always_ff @(posedge clk) begin
    if (noteon_commit) begin
      id_mem[pick] <= id_q;
    end
    if (cmd.issue) begin
      rd_id <= id_mem[cnt];
    end
  end

  always_ff @(posedge clk) begin
    if (noteon_commit) begin
      level_mem[pick] <= 16'd0;
    end else if (report_commit) begin
      level_mem[rs_addr] <= rlevel_q;
    end
    if (cmd.issue) begin
      rd_level <= level_mem[cnt];
    end
  end

  always_ff @(posedge clk) begin
    if (noteon_commit) begin
      order_mem[pick] <= stamp_next;
    end
    if (cmd.issue) begin
      rd_order <= order_mem[cnt];
    end
  end

  // compare unit, one slot per cycle
  assign act_i = active[rd_idx];
  assign rel_i = releasing[rd_idx];

  assign off_take = (op_q == pva_pkg::OP_NOTEOFF) && act_i && !rel_i &&
                    (rd_note == note_q) && (rd_chan == chan_q) &&
                    ((id_q == 32'd0) || (rd_id == id_q)) &&
                    (!have_best || (rd_order < best_order));

  assign steal_cmp = (rel_i && !best_rel) ||
                     (rel_i && best_rel && (rd_level < best_level)) ||
                     ((rel_i == best_rel) && (!rel_i || (rd_level == best_level)) &&
                      (rd_order < best_order));

  assign steal_take = (op_q == pva_pkg::OP_NOTEON) && (!have_best || steal_cmp);
  assign free_take  = (op_q == pva_pkg::OP_NOTEON) && !act_i && !free_found;

  always_ff @(posedge clk) begin
    if (rst) begin
      have_best  <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd.accept) begin
      have_best  <= 1'b0;
      free_found <= 1'b0;
    end else if (rd_vld) begin
      if (free_take) begin
        free_found <= 1'b1;
      end
      if (off_take || steal_take) begin
        have_best <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld) begin
      if (free_take) begin
        free_idx <= rd_idx;
      end
      if (off_take || steal_take) begin
        best_idx   <= rd_idx;
        best_order <= rd_order;
        best_rel   <= rel_i;
        best_level <= rd_level;
      end
    end
  end

  // voice flags and order counter
  always_ff @(posedge clk) begin
    if (rst) begin
      active        <= '0;
      releasing     <= '0;
      order_counter <= '0;
    end else if (cmd.commit) begin
      case (op_q)
        pva_pkg::OP_REPORT: begin
          if (rs_in_range && rended_q) begin
            active[rs_addr]    <= 1'b0;
            releasing[rs_addr] <= 1'b0;
          end
        end
        pva_pkg::OP_ALLOFF: begin
          releasing <= releasing | newrel;
        end
        pva_pkg::OP_NOTEOFF: begin
          if (have_best) begin
            releasing[best_idx] <= 1'b1;
          end
        end
        pva_pkg::OP_NOTEON: begin
          active[pick]    <= 1'b1;
          releasing[pick] <= 1'b0;
          order_counter   <= stamp_next;
        end
        default: begin
          active <= active;
        end
      endcase
    end
  end

  always_comb begin
    res_status = pva_pkg::RES_DONE;
    res_slot   = 3'd0;
    res_stolen = 1'b0;
    res_stamp  = 32'd0;
    res_vel    = 16'd0;
    res_mask   = 8'd0;
    case (op_q)
      pva_pkg::OP_REPORT: begin
        res_slot = rslot_q;
      end
      pva_pkg::OP_REJECT: begin
        res_status = pva_pkg::RES_REJECT;
      end
      pva_pkg::OP_ALLOFF: begin
        res_mask = newrel_mask;
      end
      pva_pkg::OP_NOTEOFF: begin
        if (have_best) begin
          res_slot = best_ext[2:0];
          res_mask = best_onehot;
        end else begin
          res_status = pva_pkg::RES_NOMATCH;
        end
      end
      pva_pkg::OP_NOTEON: begin
        res_slot   = pick_ext[2:0];
        res_stolen = !free_found;
        res_stamp  = stamp_next;
        res_vel    = vel_q;
      end
      default: begin
        res_status = pva_pkg::RES_DONE;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.commit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status         <= res_status;
      slot           <= res_slot;
      stolen         <= res_stolen;
      order_stamp    <= res_stamp;
      start_velocity <= res_vel;
      release_mask   <= res_mask;
    end
  end

endmodule

@@ rtl/polyphonic_voice_allocator.sv @@
// ----------------------------------------------------------------------------
// polyphonic_voice_allocator
// voice slot allocator with stealing, note release and envelope status feedback
//
//   channel   direction  handshake             beat
//   event     in         event_valid/stall     action, note, channel, ids, report
//   result    out        result_valid/stall    status, slot, stamp, velocity, mask
//   cfg       in         cfg_valid/cfg_ready   engine_ready
//
// note on and note off beats run accept, slot scan, drain and commit, in that order;
// the slot scan reads one slot a cycle; other beats go from accept straight to commit
// one event is in flight at a time
// result stall only holds the commit step; the result register frees the input
// reset is synchronous; the slot memories need no clearing pass
// ----------------------------------------------------------------------------
`include "polyphonic_voice_allocator_defines.svh"

module polyphonic_voice_allocator #(
  parameter int VOICES = pva_pkg::VOICES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        engine_ready,
  input  logic        event_valid,
  output logic        event_stall,
  input  logic [1:0]  action,
  input  logic [6:0]  note,
  input  logic [3:0]  channel,
  input  logic [31:0] note_id,
  input  logic [15:0] velocity,
  input  logic [2:0]  report_slot,
  input  logic [15:0] report_level,
  input  logic        report_ended,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  status,
  output logic [2:0]  slot,
  output logic        stolen,
  output logic [31:0] order_stamp,
  output logic [15:0] start_velocity,
  output logic [7:0]  release_mask
);

  pva_pkg::ctl_cmd_t cmd;
  pva_pkg::dp_stat_t stat;
  logic              cfg_wr;
  logic              out_nomatch;

  assign cfg_ready   = 1'b1;
  assign cfg_wr      = cfg_valid && cfg_ready;
  assign out_nomatch = result_valid && (status == pva_pkg::RES_NOMATCH);

  pva_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .event_valid (event_valid),
    .event_stall (event_stall),
    .stat        (stat),
    .cmd         (cmd)
  );

  pva_dp #(
    .VOICES (VOICES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_wr         (cfg_wr),
    .cfg_data       (engine_ready),
    .action         (action),
    .note           (note),
    .channel        (channel),
    .note_id        (note_id),
    .velocity       (velocity),
    .report_slot    (report_slot),
    .report_level   (report_level),
    .report_ended   (report_ended),
    .result_stall   (result_stall),
    .result_valid   (result_valid),
    .status         (status),
    .slot           (slot),
    .stolen         (stolen),
    .order_stamp    (order_stamp),
    .start_velocity (start_velocity),
    .release_mask   (release_mask)
  );

  `PVA_ASSERT_NXT(a_busy_after_accept, event_valid && !event_stall, event_stall)
  `PVA_ASSERT_NXT(a_commit_loads_result, cmd.commit, result_valid)
  `PVA_ASSERT_IMP(a_commit_not_blocked, cmd.commit, !result_valid || !result_stall)
  `PVA_ASSERT_IMP(a_nomatch_clean, out_nomatch, release_mask == 8'd0 && slot == 3'd0 && !stolen)

endmodule
